[src/async_and_hdlc_bit_framer_macros.svh]
// Assertion macros shared by the framer RTL.
`ifndef ASYNC_AND_HDLC_BIT_FRAMER_MACROS_SVH
`define ASYNC_AND_HDLC_BIT_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");

// Next-cycle implication, checked outside reset.
`define AFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");

`endif

[src/afb_pkg.sv]
// Shared types, constants and helpers for the serial line bit framer.
package afb_pkg;

   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int HIST_W   = 5;
   localparam int FRAME_W  = 10;
   localparam int CNT_W    = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ASYNC_CHAR = 3'd0,
      OP_ASYNC_IDLE = 3'd1,
      OP_SYNC_DATA  = 3'd2,
      OP_SYNC_FLAG  = 3'd3,
      OP_SYNC_ABORT = 3'd4,
      OP_RESET_HIST = 3'd5
   } op_type;

   localparam logic [FRAME_W-1:0] ASYNC_STOP  = 10'h200;
   localparam logic [FRAME_W-1:0] ASYNC_IDLE  = 10'h3ff;
   localparam logic [HIST_W-1:0]  HIST_ONES   = 5'h1f;
   localparam logic [BYTE_W-1:0]  FLAG_OCTET  = 8'h7e;
   localparam logic [BYTE_W-1:0]  ABORT_OCTET = 8'h7f;

   localparam logic [CNT_W-1:0]   ASYNC_BITS  = 4'd10;
   localparam logic [CNT_W-1:0]   OCTET_BITS  = 4'd8;

   // Mirror an octet so MSB-first bits leave from bit 0.
   function automatic logic [BYTE_W-1:0] reverse_octet(input logic [BYTE_W-1:0] value);
      logic [BYTE_W-1:0] result;
      for (int i = 0; i < BYTE_W; i++) begin
         result[i] = value[BYTE_W-1-i];
      end
      return result;
   endfunction

endpackage

[src/afb_if.sv]
// Valid/ready channel interfaces for framer requests and line bit words.
interface afb_req_if;
   import afb_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface afb_rsp_if;
   logic valid;
   logic ready;
   logic line_bit;
   logic stuffed;
   logic last_of_run;

   modport source (output valid, output line_bit, output stuffed, output last_of_run,
                   input ready);
   modport sink   (input valid, input line_bit, input stuffed, input last_of_run,
                   output ready);
endinterface

[src/async_and_hdlc_bit_framer.sv]
// Serial line bit framer: async character framing and HDLC bit stuffing.
//
//   channel   dir   handshake          word contents
//   req_ch    in    valid/ready        operation[2:0], data_byte[7:0]
//   rsp_ch    out   valid/ready        line_bit, stuffed, last_of_run
//
// One line bit leaves per cycle unless rsp_ch stalls: async char and idle are 10
// line bits, flag and abort 8, sync data 8 to 10 depending on stuffed zeros.
// A reset-history or unused operation emits no word.
// The next request is taken in the cycle the current one's last bit is loaded
// into the output register, so runs follow without a gap.
// Synchronous reset clears the history, serializer and output valid.
// A stalled rsp_ch holds the output register and pauses the serializer.
`include "async_and_hdlc_bit_framer_macros.svh"

module async_and_hdlc_bit_framer (
   input  logic          clock,
   input  logic          reset,
   afb_req_if.sink       req_ch,
   afb_rsp_if.source     rsp_ch
);
   import afb_pkg::*;

   logic                  active_ff,       active_in;
   logic                  sync_data_ff,    sync_data_in;
   logic                  stuff_pend_ff,   stuff_pend_in;
   logic [FRAME_W-1:0]    shift_ff,        shift_in;
   logic [CNT_W-1:0]      remain_ff,       remain_in;
   logic [HIST_W-1:0]     hist_ff,         hist_in;
   logic                  out_valid_ff,    out_valid_in;
   logic                  out_bit_ff,      out_bit_in;
   logic                  out_stuff_ff,    out_stuff_in;
   logic                  out_last_ff,     out_last_in;

   logic                  gen_fire;
   logic                  gen_bit;
   logic                  gen_last;
   logic                  stuff_next;
   logic                  req_take;
   logic                  req_ready;
   logic [HIST_W-1:0]     hist_after;

   // Serializer advances whenever the output register is free or draining.
   assign gen_fire   = active_ff && (!out_valid_ff || rsp_ch.ready);
   assign gen_bit    = stuff_pend_ff ? 1'b0 : shift_ff[0];
   assign hist_after = {hist_ff[HIST_W-2:0], gen_bit};
   assign stuff_next = !stuff_pend_ff && sync_data_ff && (hist_after == HIST_ONES);
   assign gen_last   = stuff_pend_ff ? (remain_ff == '0)
                                     : ((remain_ff == CNT_W'(1)) && !stuff_next);

   assign req_ready  = !active_ff || (gen_fire && gen_last);
   assign req_take   = req_ch.valid && req_ready;

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.line_bit    = out_bit_ff;
   assign rsp_ch.stuffed     = out_stuff_ff;
   assign rsp_ch.last_of_run = out_last_ff;

   always_comb begin
      active_in     = active_ff;
      sync_data_in  = sync_data_ff;
      stuff_pend_in = stuff_pend_ff;
      shift_in      = shift_ff;
      remain_in     = remain_ff;
      hist_in       = hist_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_bit_in    = out_bit_ff;
      out_stuff_in  = out_stuff_ff;
      out_last_in   = out_last_ff;

      if (gen_fire) begin
         out_valid_in  = 1'b1;
         out_bit_in    = gen_bit;
         out_stuff_in  = stuff_pend_ff;
         out_last_in   = gen_last;
         hist_in       = hist_after;
         stuff_pend_in = stuff_next;
         if (!stuff_pend_ff) begin
            shift_in  = {1'b0, shift_ff[FRAME_W-1:1]};
            remain_in = remain_ff - CNT_W'(1);
         end
         if (gen_last) begin
            active_in = 1'b0;
         end
      end

      if (req_take) begin
         stuff_pend_in = 1'b0;
         unique case (req_ch.operation)
            OP_ASYNC_CHAR: begin
               active_in    = 1'b1;
               sync_data_in = 1'b0;
               shift_in     = ASYNC_STOP | {1'b0, req_ch.data_byte, 1'b0};
               remain_in    = ASYNC_BITS;
            end
            OP_ASYNC_IDLE: begin
               active_in    = 1'b1;
               sync_data_in = 1'b0;
               shift_in     = ASYNC_IDLE;
               remain_in    = ASYNC_BITS;
            end
            OP_SYNC_DATA: begin
               active_in    = 1'b1;
               sync_data_in = 1'b1;
               shift_in     = {2'b00, reverse_octet(req_ch.data_byte)};
               remain_in    = OCTET_BITS;
            end
            OP_SYNC_FLAG: begin
               active_in    = 1'b1;
               sync_data_in = 1'b0;
               shift_in     = {2'b00, reverse_octet(FLAG_OCTET)};
               remain_in    = OCTET_BITS;
            end
            OP_SYNC_ABORT: begin
               active_in    = 1'b1;
               sync_data_in = 1'b0;
               shift_in     = {2'b00, reverse_octet(ABORT_OCTET)};
               remain_in    = OCTET_BITS;
            end
            OP_RESET_HIST: begin
               // Clear wins over the last bit of the previous run.
               hist_in = '0;
            end
            default: begin
               // Unused codes: drop the word.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         stuff_pend_ff <= 1'b0;
         hist_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         stuff_pend_ff <= stuff_pend_in;
         hist_ff       <= hist_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sync_data_ff <= sync_data_in;
      shift_ff     <= shift_in;
      remain_ff    <= remain_in;
      out_bit_ff   <= out_bit_in;
      out_stuff_ff <= out_stuff_in;
      out_last_ff  <= out_last_in;
   end

   `AFB_ASSERT_NOW(a_stuff_needs_ones, clock, reset, stuff_pend_ff, hist_ff == HIST_ONES)
   `AFB_ASSERT_NOW(a_take_only_at_end, clock, reset, req_take && active_ff, gen_fire && gen_last)
   `AFB_ASSERT_NOW(a_bits_remain, clock, reset, active_ff && !stuff_pend_ff, remain_ff != '0)
   `AFB_ASSERT_NEXT(a_run_ends, clock, reset, gen_fire && gen_last && !req_ch.valid, !active_ff)

endmodule
